// ===== rtl/core/version_rollback_check_top_defines.svh =====
// ---------------------------------------------------------------------------
// Version rollback check assertion macros
// Concurrent assertion wrappers used by the rollback check RTL. They are
// empty when the design is read for synthesis.
// ---------------------------------------------------------------------------
`ifndef VERSION_ROLLBACK_CHECK_TOP_DEFINES_SVH
`define VERSION_ROLLBACK_CHECK_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk and held off during reset.
`define VRC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rollback check assertion failed");

// Next-cycle implication, sampled on clk and held off during reset.
`define VRC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rollback check assertion failed");

`else

`define VRC_ASSERT_NOW(label, ante, cons)
`define VRC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/core/vrc_pkg.sv =====
// ---------------------------------------------------------------------------
// Version rollback check package
// Shared codes, default sizes and character constants.
// ---------------------------------------------------------------------------
package vrc_pkg;

  // Default sizes of the block.
  localparam int MAX_STRING_CHARS_DEFAULT = 32;
  localparam int COMPONENT_WIDTH_DEFAULT  = 32;

  // Number of components in one version string.
  localparam int NUM_COMPONENTS = 3;
  localparam int NUM_STRINGS    = 3;

  // Item function codes.
  typedef enum logic [1:0] {
    FUNC_INSTALLED = 2'd0,
    FUNC_CANDIDATE = 2'd1,
    FUNC_FLOOR     = 2'd2,
    FUNC_EVALUATE  = 2'd3
  } func_t;

  // String slots, in the order of the function codes.
  localparam int STR_INSTALLED = 0;
  localparam int STR_CANDIDATE = 1;
  localparam int STR_FLOOR     = 2;

  // Refusal reason codes.
  localparam logic [1:0] REASON_NONE      = 2'd0;
  localparam logic [1:0] REASON_DOWNGRADE = 2'd1;
  localparam logic [1:0] REASON_FLOOR     = 2'd2;

  // Version order codes.
  localparam logic signed [1:0] ORDER_OLDER = -2'sd1;
  localparam logic signed [1:0] ORDER_EQUAL = 2'sd0;
  localparam logic signed [1:0] ORDER_NEWER = 2'sd1;

  // Character codes.
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

endpackage

// ===== rtl/core/vrc_parser.sv =====
// ---------------------------------------------------------------------------
// Version string parser
// Parses one MAJOR.MINOR.PATCH string, one character per cycle, and keeps
// the three component values and the parse state.
// ---------------------------------------------------------------------------
module vrc_parser #(
  parameter int MAX_STRING_CHARS = vrc_pkg::MAX_STRING_CHARS_DEFAULT,
  parameter int COMPONENT_WIDTH  = vrc_pkg::COMPONENT_WIDTH_DEFAULT
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          take,
  input  logic                                          clear,
  input  logic [7:0]                                    char_code,
  output logic [vrc_pkg::NUM_COMPONENTS*COMPONENT_WIDTH-1:0] values,
  output logic                                          parse_ok
);
  import vrc_pkg::*;

  localparam int CountW   = (MAX_STRING_CHARS > 2) ? $clog2(MAX_STRING_CHARS) : 1;
  localparam int ProductW = COMPONENT_WIDTH + 4;
  localparam logic [CountW-1:0] CharLimit = CountW'(MAX_STRING_CHARS - 1);

  // Parser phase, one-hot.
  typedef enum logic [4:0] {
    PH_START  = 5'b00001,
    PH_SIGN   = 5'b00010,
    PH_DIGITS = 5'b00100,
    PH_DONE   = 5'b01000,
    PH_FAIL   = 5'b10000
  } phase_t;

  phase_t                     phase, phase_next;
  logic [1:0]                 comp_index, comp_index_next;
  logic                       neg, neg_next;
  logic [CountW-1:0]          chars_taken, chars_taken_next;
  logic                       first_nonzero, first_nonzero_next;
  logic [COMPONENT_WIDTH-1:0] comp, comp_next [NUM_COMPONENTS];
  logic [COMPONENT_WIDTH-1:0] comp_q [NUM_COMPONENTS];
  logic [1:0]                 slot;
  logic                       is_digit;
  logic                       is_space;
  logic [3:0]                 digit_val;
  logic [ProductW-1:0]        product;
  logic [COMPONENT_WIDTH-1:0] sat_value;
  phase_t                     end_phase;

  // Phase reached when the string ends in the current state.
  function automatic phase_t terminate(input phase_t ph, input logic negative,
                                       input logic nonzero);
    phase_t res;
    res = ph;
    unique case (ph)
      PH_START, PH_SIGN: res = PH_FAIL;
      PH_DIGITS:         res = (negative && nonzero) ? PH_FAIL : PH_DONE;
      PH_DONE, PH_FAIL:  res = ph;
      default:           res = PH_FAIL;
    endcase
    return res;
  endfunction

  // Character classes and the saturating decimal accumulate.
  always_comb begin
    slot      = (comp_index == 2'd3) ? 2'd2 : comp_index;
    comp      = comp_q[slot];
    is_digit  = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
    is_space  = (char_code == CHAR_SPACE) ||
                ((char_code >= CHAR_TAB) && (char_code <= CHAR_CR));
    digit_val = char_code[3:0] - CHAR_ZERO[3:0];
    product   = {1'b0, comp, 3'b000} + {3'b000, comp, 1'b0} + ProductW'(digit_val);
    sat_value = (product[ProductW-1:COMPONENT_WIDTH] != 4'd0) ?
                {COMPONENT_WIDTH{1'b1}} : product[COMPONENT_WIDTH-1:0];
    end_phase = terminate(phase, neg, comp != '0);
  end

  // Next-state logic for one character transfer or a clear.
  always_comb begin
    phase_next         = phase;
    comp_index_next    = comp_index;
    neg_next           = neg;
    chars_taken_next   = chars_taken;
    first_nonzero_next = first_nonzero;
    for (int i = 0; i < NUM_COMPONENTS; i++) begin
      comp_next[i] = comp_q[i];
    end
    if (clear) begin
      phase_next         = PH_START;
      comp_index_next    = 2'd0;
      neg_next           = 1'b0;
      chars_taken_next   = '0;
      first_nonzero_next = 1'b0;
      for (int i = 0; i < NUM_COMPONENTS; i++) begin
        comp_next[i] = '0;
      end
    end else if (take && (phase != PH_DONE) && (phase != PH_FAIL)) begin
      if (chars_taken >= CharLimit) begin
        // An overlong string ends here.
        phase_next = end_phase;
      end else begin
        if (chars_taken == '0) begin
          first_nonzero_next = (char_code != CHAR_NUL);
        end
        chars_taken_next = chars_taken + CountW'(1);
        unique case (phase)
          PH_START, PH_SIGN: begin
            if (is_digit) begin
              comp_next[slot] = COMPONENT_WIDTH'(digit_val);
              phase_next      = PH_DIGITS;
            end else if ((phase == PH_START) && is_space) begin
              phase_next = PH_START;
            end else if ((phase == PH_START) &&
                         ((char_code == CHAR_PLUS) || (char_code == CHAR_MINUS))) begin
              neg_next   = (char_code == CHAR_MINUS);
              phase_next = PH_SIGN;
            end else begin
              phase_next = PH_FAIL;
            end
          end
          PH_DIGITS: begin
            if (is_digit) begin
              comp_next[slot] = sat_value;
            end else if (neg && (comp != '0)) begin
              phase_next = PH_FAIL;
            end else if ((char_code == CHAR_DOT) && (comp_index < 2'd2)) begin
              comp_index_next = comp_index + 2'd1;
              neg_next        = 1'b0;
              phase_next      = PH_START;
            end else begin
              phase_next = PH_DONE;
            end
          end
          default: phase_next = phase;
        endcase
      end
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_START;
      comp_index    <= 2'd0;
      neg           <= 1'b0;
      chars_taken   <= '0;
      first_nonzero <= 1'b0;
      for (int i = 0; i < NUM_COMPONENTS; i++) begin
        comp_q[i] <= '0;
      end
    end else begin
      phase         <= phase_next;
      comp_index    <= comp_index_next;
      neg           <= neg_next;
      chars_taken   <= chars_taken_next;
      first_nonzero <= first_nonzero_next;
      for (int i = 0; i < NUM_COMPONENTS; i++) begin
        comp_q[i] <= comp_next[i];
      end
    end
  end

  // Major component sits in the top bits so a plain compare orders versions.
  assign values   = {comp_q[0], comp_q[1], comp_q[2]};
  assign parse_ok = first_nonzero && (end_phase == PH_DONE);

endmodule

// ===== rtl/core/vrc_decide.sv =====
// ---------------------------------------------------------------------------
// Version rollback decision
// Compares the parsed versions on evaluate and holds the verdict in the
// result register until it is transferred.
// ---------------------------------------------------------------------------
module vrc_decide #(
  parameter int COMPONENT_WIDTH = vrc_pkg::COMPONENT_WIDTH_DEFAULT
) (
  input  logic                                               clk,
  input  logic                                               rst,
  input  logic                                               eval_fire,
  input  logic                                               permit_older,
  input  logic [vrc_pkg::NUM_COMPONENTS*COMPONENT_WIDTH-1:0] inst_values,
  input  logic [vrc_pkg::NUM_COMPONENTS*COMPONENT_WIDTH-1:0] cand_values,
  input  logic [vrc_pkg::NUM_COMPONENTS*COMPONENT_WIDTH-1:0] floor_values,
  input  logic [vrc_pkg::NUM_STRINGS-1:0]                    parse_ok,
  input  logic                                               out_stall,
  output logic                                               out_valid,
  output logic                                               result_free,
  output logic                                               accepted,
  output logic [1:0]                                         refusal_reason,
  output logic signed [1:0]                                  version_order,
  output logic                                               order_valid
);
  import vrc_pkg::*;

  logic              inst_ok, cand_ok, floor_ok;
  logic              cand_newer, cand_older, below_floor;
  logic              order_ok;
  logic [1:0]        reason;
  logic signed [1:0] order;
  logic              out_valid_next;

  // Comparisons and the verdict.
  always_comb begin
    inst_ok     = parse_ok[STR_INSTALLED];
    cand_ok     = parse_ok[STR_CANDIDATE];
    floor_ok    = parse_ok[STR_FLOOR];
    cand_newer  = cand_values > inst_values;
    cand_older  = cand_values < inst_values;
    below_floor = inst_values < floor_values;
    order_ok    = inst_ok && cand_ok;
    if (!order_ok) begin
      order = ORDER_EQUAL;
    end else if (cand_older) begin
      order = ORDER_OLDER;
    end else if (cand_newer) begin
      order = ORDER_NEWER;
    end else begin
      order = ORDER_EQUAL;
    end
    priority if (order_ok && cand_older && !permit_older) begin
      reason = REASON_DOWNGRADE;
    end else if (inst_ok && floor_ok && below_floor) begin
      reason = REASON_FLOOR;
    end else begin
      reason = REASON_NONE;
    end
  end

  // The result register is free when empty or being transferred.
  assign result_free    = !out_valid || !out_stall;
  assign out_valid_next = eval_fire || (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (eval_fire) begin
      accepted       <= (reason == REASON_NONE);
      refusal_reason <= reason;
      version_order  <= order;
      order_valid    <= order_ok;
    end
  end

endmodule

// ===== rtl/core/version_rollback_check_top.sv =====
// ---------------------------------------------------------------------------
// Version rollback check top level
// Parses installed, candidate and floor version strings and decides whether
// the candidate may be installed.
// ---------------------------------------------------------------------------
// The block takes one item per clock while the input does not stall: a
// character of the installed, candidate or floor string, or an evaluate
// command. Each transfer is registered and applied to its string parser in the
// following cycle, so a new character can be taken every cycle; the parser
// update with its multiply by ten sets that rate. An evaluate's verdict is
// loaded into the result register from the input register once the evaluate
// proceeds, and the evaluate clears all three parsers. Characters keep flowing
// while an earlier verdict waits under stall, but an evaluate that reaches the
// input register then holds there, and the input stalls, until the result
// register is free. The user writes the downgrade permission through cfg_wr_en
// and cfg_wr_data only while the block is idle; the block does not enforce it.
`include "version_rollback_check_top_defines.svh"

module version_rollback_check_top #(
  parameter int MAX_STRING_CHARS = vrc_pkg::MAX_STRING_CHARS_DEFAULT,
  parameter int COMPONENT_WIDTH  = vrc_pkg::COMPONENT_WIDTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        func,
  input  logic [7:0]        char_code,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              accepted,
  output logic [1:0]        refusal_reason,
  output logic signed [1:0] version_order,
  output logic              order_valid
);
  import vrc_pkg::*;

  localparam int ValuesW = NUM_COMPONENTS * COMPONENT_WIDTH;

  logic                   allow_q;
  logic                   in_q_valid;
  func_t                  func_q;
  logic [7:0]             char_q;
  logic                   result_free;
  logic                   item_fire;
  logic                   eval_fire;
  logic [NUM_STRINGS-1:0] take;
  logic [NUM_STRINGS-1:0] parse_ok;
  logic [ValuesW-1:0]     values [NUM_STRINGS];

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      allow_q <= 1'b0;
    end else if (cfg_wr_en) begin
      allow_q <= cfg_wr_data;
    end
  end

  // The held item proceeds unless it is an evaluate facing a full result.
  assign item_fire = in_q_valid && ((func_q != FUNC_EVALUATE) || result_free);
  assign eval_fire = item_fire && (func_q == FUNC_EVALUATE);
  assign in_stall  = in_q_valid && !item_fire;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      func_q <= func_t'(func);
      char_q <= char_code;
    end
  end

  // Route a character transfer to its string parser.
  always_comb begin
    take = '0;
    unique case (func_q)
      FUNC_INSTALLED: take[STR_INSTALLED] = item_fire;
      FUNC_CANDIDATE: take[STR_CANDIDATE] = item_fire;
      FUNC_FLOOR:     take[STR_FLOOR]     = item_fire;
      FUNC_EVALUATE:  take = '0;
      default:        take = '0;
    endcase
  end

  // One parser per string.
  for (genvar s = 0; s < NUM_STRINGS; s++) begin : g_parser
    vrc_parser #(
      .MAX_STRING_CHARS (MAX_STRING_CHARS),
      .COMPONENT_WIDTH  (COMPONENT_WIDTH)
    ) u_parser (
      .clk       (clk),
      .rst       (rst),
      .take      (take[s]),
      .clear     (eval_fire),
      .char_code (char_q),
      .values    (values[s]),
      .parse_ok  (parse_ok[s])
    );
  end

  // Decision and result register.
  vrc_decide #(
    .COMPONENT_WIDTH (COMPONENT_WIDTH)
  ) u_decide (
    .clk             (clk),
    .rst             (rst),
    .eval_fire       (eval_fire),
    .permit_older    (allow_q),
    .inst_values     (values[STR_INSTALLED]),
    .cand_values     (values[STR_CANDIDATE]),
    .floor_values    (values[STR_FLOOR]),
    .parse_ok        (parse_ok),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .result_free     (result_free),
    .accepted        (accepted),
    .refusal_reason  (refusal_reason),
    .version_order   (version_order),
    .order_valid     (order_valid)
  );

  // An evaluate that proceeds always leaves a result behind.
  `VRC_ASSERT_NEXT(a_eval_gives_result, eval_fire, out_valid)
  // The accepted flag agrees with the refusal reason.
  `VRC_ASSERT_NOW(a_accept_matches_reason, out_valid, accepted == (refusal_reason == REASON_NONE))
  // Without a valid order the order reads as equal.
  `VRC_ASSERT_NOW(a_order_cleared, out_valid && !order_valid, version_order == ORDER_EQUAL)
  // A downgrade refusal needs an older candidate and a valid order.
  `VRC_ASSERT_NOW(a_downgrade_older, out_valid && (refusal_reason == REASON_DOWNGRADE), order_valid && (version_order == ORDER_OLDER))

endmodule
